/* sv/pgke_pkg.sv */
// Shared types and constants for the gridding kernel evaluator.
// Holds the Q30 coefficient tables and the inter-stage payload structs; no dependencies.
`timescale 1ns / 1ps

package pgke_pkg;

    localparam int QB = 30;
    localparam int OUT_W = 18;
    localparam int IN_W = 16;
    localparam int CFG_W = 5;
    localparam logic [CFG_W-1:0] SUPPORT_OK = 5'd6;
    localparam logic [CFG_W-1:0] SUPPORT_RESET = 5'd6;
    localparam int FRAC_BITS_IN_DEF = 12;
    localparam int FRAC_BITS_OUT_DEF = 16;

    // Rounds a coefficient given in units of 1e-9 to the nearest Q30 value.
    function automatic longint qc(input longint m);
        longint r;
        if (m < 0) begin
            r = -(((-m) * 64'sd1073741824 + 64'sd500000000) / 64'sd1000000000);
        end else begin
            r = (m * 64'sd1073741824 + 64'sd500000000) / 64'sd1000000000;
        end
        return r;
    endfunction

    localparam logic signed [31:0] NUM_IN [5] = '{
        32'(qc(82033430)), 32'(qc(-364470500)), 32'(qc(627866000)),
        32'(qc(-533558100)), 32'(qc(231275600))
    };
    localparam logic signed [31:0] NUM_OUT [5] = '{
        32'(qc(4028559)), 32'(qc(-36977680)), 32'(qc(102133200)),
        32'(qc(-120143600)), 32'(qc(64127740))
    };
    localparam logic signed [31:0] DEN_IN [3] = '{
        32'(qc(1000000000)), 32'(qc(821201800)), 32'(qc(207804300))
    };
    localparam logic signed [31:0] DEN_OUT [3] = '{
        32'(qc(1000000000)), 32'(qc(959910200)), 32'(qc(291872400))
    };

    // Front end to polynomial section.
    typedef struct packed {
        logic               flag;
        logic               region;
        logic signed [31:0] eta;
        logic [30:0]        omt;
    } pgke_eta_t;

    // Polynomial section to divider.
    typedef struct packed {
        logic               flag;
        logic [30:0]        omt;
        logic signed [31:0] num;
        logic signed [31:0] den;
    } pgke_nd_t;

    // Divider to output section.
    typedef struct packed {
        logic        flag;
        logic [30:0] omt;
        logic        neg;
        logic [31:0] quo;
    } pgke_quo_t;

endpackage

/* sv/pgke_front.sv */
// Front end: magnitude, range checks, eta0 squared in Q30 and the shifted Horner variable.
// Depends on pgke_pkg.
`timescale 1ns / 1ps

module pgke_front #(
    parameter int FRAC_BITS_IN = pgke_pkg::FRAC_BITS_IN_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [pgke_pkg::CFG_W-1:0]          support_size,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [pgke_pkg::IN_W-1:0]    x_offset,
    output logic                                out_valid,
    input  logic                                out_ready,
    output pgke_pkg::pgke_eta_t                 out_data
);
    import pgke_pkg::*;

    localparam int NS = 6;
    localparam int T_SHIFT = 20 - FRAC_BITS_IN;
    localparam logic [31:0] LIM = 32'(3) << FRAC_BITS_IN;
    localparam logic [33:0] REG_LIM = 34'(9) << FRAC_BITS_IN;
    localparam logic [31:0] RECIP = 32'd3817748708;
    localparam logic [44:0] E2_HALF = 45'd4608;
    localparam logic signed [31:0] EDGE_IN = 32'sd9 <<< 26;
    localparam logic signed [31:0] EDGE_OUT = 32'sd1 <<< QB;
    localparam logic [30:0] ONE_Q = 31'd1 << QB;

    logic [NS-1:0] v_reg;
    logic [NS:0]   en;

    always_comb
    begin
        en[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready = en[0];
    assign out_valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) begin
                    v_reg[k] <= (k == 0) ? in_valid : v_reg[k-1];
                end
            end
        end
    end

    // Stage 0: magnitude and range decisions.
    logic [15:0] a_mag;
    logic        flag_next;
    logic [35:0] t_wide;
    logic [21:0] t_reg;
    logic        flag_reg [NS];
    logic        region_reg [NS];

    always_comb
    begin
        a_mag = x_offset[15] ? (~x_offset[15:0] + 16'd1) : x_offset[15:0];
        flag_next = (support_size != SUPPORT_OK) || (32'(a_mag) > LIM);
        t_wide = (36'(a_mag) << T_SHIFT);
        if (flag_next) begin
            t_wide = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0]) begin
            t_reg <= t_wide[21:0];
            flag_reg[0] <= flag_next;
            region_reg[0] <= ((34'(a_mag) << 2) <= REG_LIM);
        end
        for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
                flag_reg[k] <= flag_reg[k-1];
                region_reg[k] <= region_reg[k-1];
            end
        end
    end

    // Stage 1: t squared.
    logic [43:0] sq_reg;
    always_ff @(posedge clk)
    begin
        if (en[1]) begin
            sq_reg <= 44'(t_reg) * 44'(t_reg);
        end
    end

    // Stage 2: divide by 1024 with rounding offset, then split the divide by 9.
    logic [44:0] sq_sum;
    logic [33:0] m_next;
    logic [33:0] m2_reg;
    logic [48:0] ph_reg;
    logic [48:0] pl_reg;
    always_comb
    begin
        sq_sum = 45'(sq_reg) + E2_HALF;
        m_next = sq_sum[43:10];
    end

    always_ff @(posedge clk)
    begin
        if (en[2]) begin
            m2_reg <= m_next;
            ph_reg <= 49'(m_next[33:17]) * 49'(RECIP);
            pl_reg <= 49'(m_next[16:0]) * 49'(RECIP);
        end
    end

    // Stage 3: combine partial products into a quotient estimate.
    logic [65:0] prod;
    logic [30:0] q0_reg;
    logic [33:0] m3_reg;
    always_comb
    begin
        prod = (66'(ph_reg) << 17) + 66'(pl_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[3]) begin
            q0_reg <= prod[65:35];
            m3_reg <= m2_reg;
        end
    end

    // Stage 4: the estimate is high by at most one.
    logic [34:0] nine_q;
    logic [30:0] e2_reg;
    always_comb
    begin
        nine_q = 35'(q0_reg) * 35'd9;
    end

    always_ff @(posedge clk)
    begin
        if (en[4]) begin
            e2_reg <= (35'(m3_reg) < nine_q) ? (q0_reg - 31'd1) : q0_reg;
        end
    end

    // Stage 5: Horner variable relative to the region edge, and 1 - eta0 squared.
    logic signed [31:0] eta_reg;
    logic [30:0]        omt_reg;
    always_ff @(posedge clk)
    begin
        if (en[5]) begin
            eta_reg <= $signed({1'b0, e2_reg}) - (region_reg[4] ? EDGE_IN : EDGE_OUT);
            omt_reg <= ONE_Q - e2_reg;
        end
    end

    assign out_data.flag = flag_reg[NS-1];
    assign out_data.region = region_reg[NS-1];
    assign out_data.eta = eta_reg;
    assign out_data.omt = omt_reg;

endmodule

/* sv/pgke_horner.sv */
// Horner evaluation of the numerator and denominator polynomials, one multiply stage
// and one round-and-add stage per step. Depends on pgke_pkg.
`timescale 1ns / 1ps

module pgke_horner (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pgke_pkg::pgke_eta_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pgke_pkg::pgke_nd_t   out_data
);
    import pgke_pkg::*;

    localparam int NSTEP = 4;
    localparam int NDSTEP = 2;
    localparam int NS = 2 * NSTEP + 1;
    localparam logic [63:0] HALF = 64'd1 << (QB - 1);

    logic [NS-1:0] v_reg;
    logic [NS:0]   en;

    always_comb
    begin
        en[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready = en[0];
    assign out_valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) begin
                    v_reg[k] <= (k == 0) ? in_valid : v_reg[k-1];
                end
            end
        end
    end

    pgke_eta_t          ctx_reg [NS];
    logic signed [31:0] num_reg [NSTEP+1];
    logic signed [31:0] den_reg [NSTEP+1];
    logic [63:0]        pn_reg [NSTEP];
    logic [63:0]        pd_reg [NSTEP];
    logic               nn_reg [NSTEP];
    logic               nd_reg [NSTEP];
    logic signed [31:0] dh_reg [NSTEP];

    // Entry stage loads the leading coefficients of the selected region.
    always_ff @(posedge clk)
    begin
        if (en[0]) begin
            ctx_reg[0] <= in_data;
            num_reg[0] <= in_data.region ? NUM_IN[4] : NUM_OUT[4];
            den_reg[0] <= in_data.region ? DEN_IN[2] : DEN_OUT[2];
        end
        for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
                ctx_reg[k] <= ctx_reg[k-1];
            end
        end
    end

    for (genvar j = 0; j < NSTEP; j++) begin : g_step
        logic [31:0]        eta_mag;
        logic [31:0]        n_mag;
        logic [31:0]        d_mag;
        logic [63:0]        n_rnd;
        logic [63:0]        d_rnd;
        logic signed [31:0] n_term;
        logic signed [31:0] d_term;
        logic signed [31:0] n_coef;
        logic signed [31:0] d_coef;

        always_comb
        begin
            eta_mag = ctx_reg[2*j].eta[31] ? 32'(-ctx_reg[2*j].eta) : 32'(ctx_reg[2*j].eta);
            n_mag = num_reg[j][31] ? 32'(-num_reg[j]) : 32'(num_reg[j]);
            d_mag = den_reg[j][31] ? 32'(-den_reg[j]) : 32'(den_reg[j]);
            n_rnd = (pn_reg[j] + HALF) >> QB;
            d_rnd = (pd_reg[j] + HALF) >> QB;
            n_term = nn_reg[j] ? -$signed(n_rnd[31:0]) : $signed(n_rnd[31:0]);
            d_term = nd_reg[j] ? -$signed(d_rnd[31:0]) : $signed(d_rnd[31:0]);
            n_coef = ctx_reg[2*j+1].region ? NUM_IN[NSTEP-1-j] : NUM_OUT[NSTEP-1-j];
            if (j < NDSTEP) begin
                d_coef = ctx_reg[2*j+1].region ? DEN_IN[NDSTEP-1-j] : DEN_OUT[NDSTEP-1-j];
            end else begin
                d_coef = '0;
            end
        end

        // Multiply stage.
        always_ff @(posedge clk)
        begin
            if (en[2*j+1]) begin
                pn_reg[j] <= 64'(n_mag) * 64'(eta_mag);
                pd_reg[j] <= 64'(d_mag) * 64'(eta_mag);
                nn_reg[j] <= num_reg[j][31] ^ ctx_reg[2*j].eta[31];
                nd_reg[j] <= den_reg[j][31] ^ ctx_reg[2*j].eta[31];
                dh_reg[j] <= den_reg[j];
            end
        end

        // Round half away from zero; add next coefficient, den only in early steps.
        always_ff @(posedge clk)
        begin
            if (en[2*j+2]) begin
                num_reg[j+1] <= n_term + n_coef;
                if (j < NDSTEP) begin
                    den_reg[j+1] <= d_term + d_coef;
                end else begin
                    den_reg[j+1] <= dh_reg[j];
                end
            end
        end
    end

    assign out_data.flag = ctx_reg[NS-1].flag;
    assign out_data.omt = ctx_reg[NS-1].omt;
    assign out_data.num = num_reg[NSTEP];
    assign out_data.den = den_reg[NSTEP];

endmodule

/* sv/pgke_div.sv */
// Pipelined restoring divider forming the rounded Q30 quotient num/den, one bit a stage.
// Depends on pgke_pkg.
`timescale 1ns / 1ps

module pgke_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pgke_pkg::pgke_nd_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pgke_pkg::pgke_quo_t  out_data
);
    import pgke_pkg::*;

    localparam int QW = 32;
    localparam int NS = QW + 1;

    logic [NS-1:0] v_reg;
    logic [NS:0]   en;

    always_comb
    begin
        en[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready = en[0];
    assign out_valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) begin
                    v_reg[k] <= (k == 0) ? in_valid : v_reg[k-1];
                end
            end
        end
    end

    logic [32:0]    rem_reg [NS];
    logic [QW-1:0]  dlo_reg [NS];
    logic [QW-1:0]  quo_reg [NS];
    logic [31:0]    ud_reg [NS];
    logic           neg_reg [NS];
    logic           flag_reg [NS];
    logic [30:0]    omt_reg [NS];

    // Setup: numerator magnitude, guarded denominator, and dividend with its rounding half.
    logic [31:0] un;
    logic [31:0] ud;
    logic [61:0] dvd;
    always_comb
    begin
        un = in_data.num[31] ? 32'(-in_data.num) : 32'(in_data.num);
        ud = (in_data.den < 32'sd1) ? 32'd1 : 32'(in_data.den);
        dvd = (62'(un) << QB) + 62'(ud >> 1);
    end

    always_ff @(posedge clk)
    begin
        if (en[0]) begin
            rem_reg[0] <= 33'(dvd[61:QW]);
            dlo_reg[0] <= dvd[QW-1:0];
            quo_reg[0] <= '0;
            ud_reg[0] <= ud;
            neg_reg[0] <= in_data.num[31];
            flag_reg[0] <= in_data.flag;
            omt_reg[0] <= in_data.omt;
        end
    end

    for (genvar k = 1; k < NS; k++) begin : g_bit
        logic [32:0] trial;
        logic        fits;
        always_comb
        begin
            trial = {rem_reg[k-1][31:0], dlo_reg[k-1][QW-1]};
            fits = (trial >= {1'b0, ud_reg[k-1]});
        end

        always_ff @(posedge clk)
        begin
            if (en[k]) begin
                rem_reg[k] <= fits ? (trial - {1'b0, ud_reg[k-1]}) : trial;
                dlo_reg[k] <= {dlo_reg[k-1][QW-2:0], 1'b0};
                quo_reg[k] <= {quo_reg[k-1][QW-2:0], fits};
                ud_reg[k] <= ud_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                flag_reg[k] <= flag_reg[k-1];
                omt_reg[k] <= omt_reg[k-1];
            end
        end
    end

    assign out_data.flag = flag_reg[NS-1];
    assign out_data.omt = omt_reg[NS-1];
    assign out_data.neg = neg_reg[NS-1];
    assign out_data.quo = quo_reg[NS-1];

endmodule

/* sv/pgke_out.sv */
// Output section: scales the quotient by 1 - eta0 squared, rounds to the output format
// and saturates; its last stage is the output register. Depends on pgke_pkg.
`timescale 1ns / 1ps

module pgke_out #(
    parameter int FRAC_BITS_OUT = pgke_pkg::FRAC_BITS_OUT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  pgke_pkg::pgke_quo_t                 in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [pgke_pkg::OUT_W-1:0]   kernel_value,
    output logic                                out_of_support
);
    import pgke_pkg::*;

    localparam int NS = 3;
    localparam int SH = QB - FRAC_BITS_OUT;
    localparam logic [63:0] HALF = 64'd1 << (QB - 1);
    localparam logic [34:0] HALF_OUT = 35'd1 << (SH - 1);
    localparam logic [34:0] POS_MAX = (35'd1 << (OUT_W - 1)) - 35'd1;
    localparam logic [34:0] NEG_MAX = 35'd1 << (OUT_W - 1);

    logic [NS-1:0] v_reg;
    logic [NS:0]   en;

    always_comb
    begin
        en[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready = en[0];
    assign out_valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) begin
                    v_reg[k] <= (k == 0) ? in_valid : v_reg[k-1];
                end
            end
        end
    end

    // Stage 0: product magnitude.
    logic [63:0] p_reg;
    logic        neg0_reg;
    logic        flag0_reg;
    always_ff @(posedge clk)
    begin
        if (en[0]) begin
            p_reg <= 64'(in_data.quo) * 64'(in_data.omt);
            neg0_reg <= in_data.neg;
            flag0_reg <= in_data.flag;
        end
    end

    // Stage 1: back to Q30.
    logic [63:0] p_rnd;
    logic [34:0] m1_reg;
    logic        neg1_reg;
    logic        flag1_reg;
    always_comb
    begin
        p_rnd = (p_reg + HALF) >> QB;
    end

    always_ff @(posedge clk)
    begin
        if (en[1]) begin
            m1_reg <= p_rnd[34:0];
            neg1_reg <= neg0_reg && (p_rnd[34:0] != '0);
            flag1_reg <= flag0_reg;
        end
    end

    // Stage 2: round to the output format and saturate.
    logic [34:0]              m2;
    logic signed [OUT_W-1:0]  val_next;
    logic signed [OUT_W-1:0]  kv_reg;
    logic                     oos_reg;
    always_comb
    begin
        m2 = (m1_reg + HALF_OUT) >> SH;
        if (flag1_reg) begin
            val_next = '0;
        end else if (neg1_reg) begin
            val_next = (m2 > NEG_MAX) ? -$signed(NEG_MAX[OUT_W-1:0])
                                      : -$signed(m2[OUT_W-1:0]);
        end else begin
            val_next = (m2 > POS_MAX) ? $signed(POS_MAX[OUT_W-1:0])
                                      : $signed(m2[OUT_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2]) begin
            kv_reg <= val_next;
            oos_reg <= flag1_reg;
        end
    end

    assign kernel_value = kv_reg;
    assign out_of_support = oos_reg;

endmodule

/* sv/pswf_gridding_kernel_eval.sv */
// Top level of the prolate spheroidal gridding kernel evaluator (support 6).
// Depends on pgke_pkg, pgke_front, pgke_horner, pgke_div and pgke_out.
//
//   Channel   Signals                                   Direction  Width
//   input     in_valid, in_stall, x_offset              in         16 signed Q4.FRAC_BITS_IN
//   output    out_valid, out_stall, kernel_value,       out        18 signed Q2.FRAC_BITS_OUT,
//             out_of_support                                       1
//   config    cfg_wr_en, cfg_wr_data (support_size)     in         5
//
// One item enters per cycle unless the pipeline stalls. There are 6 front stages, 9 Horner
// stages, 33 divider stages (a setup stage, then one quotient bit each) and 3 output stages.
// Reset clears all valid bits and sets support_size to 6.
// Every stage holds its item only while the stage after it is full and blocked, so bubbles
// close up under a stall and in_stall rises only when the whole pipeline is full.
`timescale 1ns / 1ps

module pswf_gridding_kernel_eval #(
    parameter int FRAC_BITS_IN = pgke_pkg::FRAC_BITS_IN_DEF,
    parameter int FRAC_BITS_OUT = pgke_pkg::FRAC_BITS_OUT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [pgke_pkg::CFG_W-1:0]          cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [pgke_pkg::IN_W-1:0]    x_offset,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [pgke_pkg::OUT_W-1:0]   kernel_value,
    output logic                                out_of_support
);
    import pgke_pkg::*;

    // Only a support width of 6 gives nonzero weights; other widths flag every item.
    logic [CFG_W-1:0] support_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            support_size_reg <= SUPPORT_RESET;
        end else if (cfg_wr_en) begin
            support_size_reg <= cfg_wr_data;
        end
    end

    logic      front_ready;
    logic      eta_valid;
    logic      eta_ready;
    pgke_eta_t eta_data;
    logic      nd_valid;
    logic      nd_ready;
    pgke_nd_t  nd_data;
    logic      quo_valid;
    logic      quo_ready;
    pgke_quo_t quo_data;

    assign in_stall = !front_ready;

    // Magnitude, range checks, eta0 squared and the Horner variable.
    pgke_front #(
        .FRAC_BITS_IN (FRAC_BITS_IN)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .support_size (support_size_reg),
        .in_valid     (in_valid),
        .in_ready     (front_ready),
        .x_offset     (x_offset),
        .out_valid    (eta_valid),
        .out_ready    (eta_ready),
        .out_data     (eta_data)
    );

    // Numerator and denominator polynomials of the selected region.
    pgke_horner u_horner (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (eta_valid),
        .in_ready  (eta_ready),
        .in_data   (eta_data),
        .out_valid (nd_valid),
        .out_ready (nd_ready),
        .out_data  (nd_data)
    );

    // Rounded quotient of the two polynomials.
    pgke_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (nd_valid),
        .in_ready  (nd_ready),
        .in_data   (nd_data),
        .out_valid (quo_valid),
        .out_ready (quo_ready),
        .out_data  (quo_data)
    );

    // Taper by 1 - eta0 squared, final rounding, saturation and the output register.
    pgke_out #(
        .FRAC_BITS_OUT (FRAC_BITS_OUT)
    ) u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (quo_valid),
        .in_ready       (quo_ready),
        .in_data        (quo_data),
        .out_valid      (out_valid),
        .out_ready      (!out_stall),
        .kernel_value   (kernel_value),
        .out_of_support (out_of_support)
    );

endmodule
